FILE: sv/lcs_pkg.sv
// Shared types and constants of the longest-common-substring unit.
package lcs_pkg;

   // Character and register widths fixed by the interface
   localparam int CHAR_W = 16;
   localparam int CFG_W  = 8;

   // Reset value of the compared-token count register
   localparam logic [CFG_W-1:0] CFG_RESET = 8'd29;

   // Token counter saturates at one past the largest register value
   localparam int              TIDX_W    = 9;
   localparam logic [TIDX_W-1:0] TOKEN_CAP = 9'd256;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } lcs_state_type;

endpackage

FILE: sv/longest_common_substring_unit.sv
// Longest common substring between a reference token and the tokens that follow it.
//
// Characters of a token set arrive one beat at a time. The first token is written to a
// reference memory (up to MAX_LEN characters, the rest dropped and flagged). Each of the
// next csr register tokens is matched against it: per incoming character the unit sweeps
// the reference and run-length memories, one position per cycle, reading both memories
// and writing the updated run back in the following cycle. A compared character holds off
// the next beat until its sweep is through; reference characters, empty items and ignored
// tokens need no sweep. One result beat (length, start, truncation flag) is given at the
// end of each set, and a new beat is accepted only when no result waits or the waiting
// one is taken in that cycle.
module longest_common_substring_unit #(
   parameter int MAX_LEN = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [lcs_pkg::CFG_W-1:0]           csr_wr_data,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lcs_pkg::CHAR_W-1:0]          req_char_code,
   input  logic                                req_has_char,
   input  logic                                req_token_end,
   input  logic                                req_set_end,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [$clog2(MAX_LEN+1)-1:0]        rsp_lcs_length,
   output logic [$clog2(MAX_LEN)-1:0]          rsp_lcs_start,
   output logic                                rsp_ref_truncated
);
   import lcs_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = $clog2(MAX_LEN);

   // Memories
   logic [CHAR_W-1:0] ref_mem [MAX_LEN];
   logic [LEN_W-1:0]  run_mem [MAX_LEN];

   // Control state
   lcs_state_type     state_ff, state_in;
   logic [CFG_W-1:0]  max_other_ff;
   logic [LEN_W-1:0]  ref_len_ff, ref_len_in;
   logic              overflow_ff, overflow_in;
   logic [TIDX_W-1:0] tidx_ff, tidx_in;
   logic [LEN_W-1:0]  tok_best_len_ff, tok_best_len_in;
   logic [LEN_W-1:0]  tok_best_end_ff, tok_best_end_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [IDX_W-1:0]  best_start_ff, best_start_in;
   logic              fresh_ff, fresh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              b_vld_ff;

   // Sweep datapath
   logic [CHAR_W-1:0] char_ff;
   logic              tok_done_ff;
   logic              set_done_ff;
   logic [LEN_W-1:0]  rd_cnt_ff;
   logic [IDX_W-1:0]  b_idx_ff;
   logic [CHAR_W-1:0] ref_q_ff;
   logic [LEN_W-1:0]  run_q_ff;
   logic [LEN_W-1:0]  old_prev_ff;
   logic [LEN_W-1:0]  step_len_ff;
   logic [LEN_W-1:0]  step_end_ff;

   // Output registers
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [IDX_W-1:0]  rsp_start_ff, rsp_start_in;
   logic              rsp_trunc_ff, rsp_trunc_in;

   // Decode
   logic              req_fire;
   logic              req_tok_done;
   logic              comparing_now;
   logic              need_sweep;
   logic              ref_wr_en;
   logic              issue;
   logic              sweep_done;
   logic              sweep_start;
   logic [IDX_W-1:0]  rd_addr;
   logic              b_match;
   logic [LEN_W-1:0]  run_old_cur;
   logic [LEN_W-1:0]  run_new;
   logic [LEN_W-1:0]  b_end;

   // Commit controls
   logic              cm_en;
   logic              cm_tok_done;
   logic              cm_set_done;
   logic              cm_comparing;
   logic              cm_fresh_clr;
   logic [LEN_W-1:0]  cm_step_len;
   logic [LEN_W-1:0]  cm_step_end;
   logic              tb_upd;
   logic [LEN_W-1:0]  tb_len_new;
   logic [LEN_W-1:0]  tb_end_new;

   assign req_ready     = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire      = req_valid && req_ready;
   assign req_tok_done  = req_token_end || req_set_end;
   assign comparing_now = (tidx_ff != '0) && (tidx_ff <= {1'b0, max_other_ff});
   assign need_sweep    = comparing_now && req_has_char && (ref_len_ff != '0);
   assign ref_wr_en     = req_fire && (tidx_ff == '0) && req_has_char
                          && (ref_len_ff < LEN_W'(MAX_LEN));

   // Sweep issue and drain
   assign issue      = (state_ff == ST_SWEEP) && (rd_cnt_ff < ref_len_ff);
   assign sweep_done = (state_ff == ST_SWEEP) && !issue && !b_vld_ff;
   assign rd_addr    = rd_cnt_ff[IDX_W-1:0];

   // Cell update: old runs read as zero on the first character of a token
   assign run_old_cur = fresh_ff ? '0 : run_q_ff;
   assign b_match     = (ref_q_ff == char_ff);
   assign run_new     = b_match ? LEN_W'(old_prev_ff + 1'b1) : '0;
   assign b_end       = LEN_W'({1'b0, b_idx_ff} + 1'b1);

   // Sequencer: next state and commit selection
   always_comb begin
      state_in     = state_ff;
      sweep_start  = 1'b0;
      cm_en        = 1'b0;
      cm_tok_done  = 1'b0;
      cm_set_done  = 1'b0;
      cm_comparing = 1'b0;
      cm_fresh_clr = 1'b0;
      cm_step_len  = '0;
      cm_step_end  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (need_sweep) begin
                  state_in    = ST_SWEEP;
                  sweep_start = 1'b1;
               end else begin
                  cm_en        = 1'b1;
                  cm_tok_done  = req_tok_done;
                  cm_set_done  = req_set_end;
                  cm_comparing = comparing_now;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in     = ST_IDLE;
               cm_en        = 1'b1;
               cm_tok_done  = tok_done_ff;
               cm_set_done  = set_done_ff;
               cm_comparing = 1'b1;
               cm_fresh_clr = 1'b1;
               cm_step_len  = step_len_ff;
               cm_step_end  = step_end_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Token best: longer wins, equal length goes to the smaller end
   assign tb_upd = (cm_step_len > tok_best_len_ff)
                   || ((cm_step_len != '0) && (cm_step_len == tok_best_len_ff)
                       && (cm_step_end < tok_best_end_ff));
   assign tb_len_new = tb_upd ? cm_step_len : tok_best_len_ff;
   assign tb_end_new = tb_upd ? cm_step_end : tok_best_end_ff;

   // Set state update, result load and set clear
   always_comb begin
      ref_len_in      = ref_len_ff;
      overflow_in     = overflow_ff;
      tidx_in         = tidx_ff;
      tok_best_len_in = tok_best_len_ff;
      tok_best_end_in = tok_best_end_ff;
      best_len_in     = best_len_ff;
      best_start_in   = best_start_ff;
      fresh_in        = fresh_ff;
      rsp_len_in      = rsp_len_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_trunc_in    = rsp_trunc_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      // reference capture
      if (req_fire && (tidx_ff == '0) && req_has_char) begin
         if (ref_len_ff < LEN_W'(MAX_LEN)) begin
            ref_len_in = LEN_W'(ref_len_ff + 1'b1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (cm_en) begin
         tok_best_len_in = tb_len_new;
         tok_best_end_in = tb_end_new;
         if (cm_fresh_clr) begin
            fresh_in = 1'b0;
         end
         // token close
         if (cm_tok_done) begin
            if (cm_comparing && (tb_len_new > best_len_ff)) begin
               best_len_in   = tb_len_new;
               best_start_in = IDX_W'(tb_end_new - tb_len_new);
            end
            tok_best_len_in = '0;
            tok_best_end_in = '0;
            fresh_in        = 1'b1;
            if (tidx_ff != TOKEN_CAP) begin
               tidx_in = TIDX_W'(tidx_ff + 1'b1);
            end
         end
         // set close: load result, then clear the set
         if (cm_set_done) begin
            rsp_valid_in    = 1'b1;
            rsp_len_in      = best_len_in;
            rsp_start_in    = best_start_in;
            rsp_trunc_in    = overflow_in;
            ref_len_in      = '0;
            overflow_in     = 1'b0;
            tidx_in         = '0;
            best_len_in     = '0;
            best_start_in   = '0;
            tok_best_len_in = '0;
            tok_best_end_in = '0;
            fresh_in        = 1'b1;
         end
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_other_ff    <= CFG_RESET;
         ref_len_ff      <= '0;
         overflow_ff     <= 1'b0;
         tidx_ff         <= '0;
         tok_best_len_ff <= '0;
         tok_best_end_ff <= '0;
         best_len_ff     <= '0;
         best_start_ff   <= '0;
         fresh_ff        <= 1'b1;
         rsp_valid_ff    <= 1'b0;
         b_vld_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_other_ff <= csr_wr_data;
         end
         ref_len_ff      <= ref_len_in;
         overflow_ff     <= overflow_in;
         tidx_ff         <= tidx_in;
         tok_best_len_ff <= tok_best_len_in;
         tok_best_end_ff <= tok_best_end_in;
         best_len_ff     <= best_len_in;
         best_start_ff   <= best_start_in;
         fresh_ff        <= fresh_in;
         rsp_valid_ff    <= rsp_valid_in;
         b_vld_ff        <= issue;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_len_ff   <= rsp_len_in;
      rsp_start_ff <= rsp_start_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   // Sweep counters, neighbor run and per-character maximum
   always_ff @(posedge clock) begin
      b_idx_ff <= rd_addr;
      if (sweep_start) begin
         char_ff     <= req_char_code;
         tok_done_ff <= req_tok_done;
         set_done_ff <= req_set_end;
         rd_cnt_ff   <= '0;
         old_prev_ff <= '0;
         step_len_ff <= '0;
         step_end_ff <= '0;
      end else begin
         if (issue) begin
            rd_cnt_ff <= LEN_W'(rd_cnt_ff + 1'b1);
         end
         if (b_vld_ff) begin
            old_prev_ff <= run_old_cur;
            // ascending sweep, strict compare keeps the smallest end
            if (run_new > step_len_ff) begin
               step_len_ff <= run_new;
               step_end_ff <= b_end;
            end
         end
      end
   end

   // Reference character memory
   always_ff @(posedge clock) begin
      if (ref_wr_en) begin
         ref_mem[ref_len_ff[IDX_W-1:0]] <= req_char_code;
      end
      if (issue) begin
         ref_q_ff <= ref_mem[rd_addr];
      end
   end

   // Run length memory: read at the issue pointer, write back one position behind
   always_ff @(posedge clock) begin
      if (b_vld_ff) begin
         run_mem[b_idx_ff] <= run_new;
      end
      if (issue) begin
         run_q_ff <= run_mem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lcs_length    = rsp_len_ff;
   assign rsp_lcs_start     = rsp_start_ff;
   assign rsp_ref_truncated = rsp_trunc_ff;

   // A result is loaded only into a free or draining output register
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cm_en && cm_set_done) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // Write-back position always lies inside the stored reference
   a_wb_in_ref: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> ({1'b0, b_idx_ff} < ref_len_ff))
      else $error("run write-back beyond reference");

   // Best runs never exceed the reference length, and a token's best end never lies below its length
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (best_len_ff <= ref_len_ff) && (tok_best_len_ff <= ref_len_ff)
      && (tok_best_end_ff >= tok_best_len_ff))
      else $error("best run out of bounds");

   // Reference length does not move while a sweep runs
   a_ref_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |=> $stable(ref_len_ff) || (state_ff == ST_IDLE))
      else $error("reference length changed during sweep");

endmodule

FILE: sim/longest_common_substring_unit_tb.sv
// Self-checking testbench for the longest-common-substring unit.
module longest_common_substring_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcs_pkg::*;

   localparam int MAX_LEN      = 64;
   localparam int LEN_W        = $clog2(MAX_LEN + 1);
   localparam int POS_W        = $clog2(MAX_LEN);
   localparam int IDLE_PCT     = 28;
   localparam int QUIET_CYCLES = MAX_LEN + 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int ITEM_TARGET  = 1400;

   // How a token is closed
   typedef enum int {
      CLOSE_ON_CHAR,
      CLOSE_MARKER,
      CLOSE_SET_ONLY
   } close_style_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [POS_W-1:0] start;
      logic             trunc;
   } lcs_result_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CFG_W-1:0]    csr_wr_data;
   logic                req_valid;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_code;
   logic                req_has_char;
   logic                req_token_end;
   logic                req_set_end;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [LEN_W-1:0]    rsp_lcs_length;
   logic [POS_W-1:0]    rsp_lcs_start;
   logic                rsp_ref_truncated;

   longest_common_substring_unit #(.MAX_LEN(MAX_LEN)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_has_char      (req_has_char),
      .req_token_end     (req_token_end),
      .req_set_end       (req_set_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_lcs_length    (rsp_lcs_length),
      .rsp_lcs_start     (rsp_lcs_start),
      .rsp_ref_truncated (rsp_ref_truncated)
   );

   // Predictor state: reference, per-position runs, token and set bests
   logic [CHAR_W-1:0] ref_text [MAX_LEN];
   int unsigned       ref_count;
   int unsigned       streak [MAX_LEN];
   int unsigned       token_no;
   int unsigned       token_best_len;
   int unsigned       token_best_end;
   int unsigned       set_best_len;
   int unsigned       set_best_start;
   bit                ref_long;
   int unsigned       token_limit;

   lcs_result_type    pending_lcs [$];
   logic [CHAR_W-1:0] token_buf [$];
   logic [CHAR_W-1:0] alphabet [4];

   int  error_count   = 0;
   int  beats_sent    = 0;
   int  in_idle_pct   = IDLE_PCT;
   int  out_idle_pct  = IDLE_PCT;
   int  noise_pct     = 0;
   bit  hold_request  = 0;
   int  stall_left    = 0;

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void clear_token_runs();
      for (int p = 0; p < MAX_LEN; p++) streak[p] = 0;
      token_best_len = 0;
      token_best_end = 0;
   endfunction

   function automatic void clear_lcs_set();
      ref_count      = 0;
      token_no       = 0;
      set_best_len   = 0;
      set_best_start = 0;
      ref_long       = 0;
      clear_token_runs();
   endfunction

   // One character against the whole reference; high positions first so each
   // cell sees its left neighbor's run from the previous character
   function automatic void match_char(logic [CHAR_W-1:0] code);
      int unsigned hi_len;
      int unsigned hi_end;
      hi_len = 0;
      hi_end = 0;
      for (int p = int'(ref_count) - 1; p >= 0; p--) begin
         if (ref_text[p] == code)
            streak[p] = ((p > 0) ? streak[p-1] : 0) + 1;
         else
            streak[p] = 0;
      end
      for (int p = 0; p < int'(ref_count); p++) begin
         if (streak[p] > hi_len) begin
            hi_len = streak[p];
            hi_end = p + 1;
         end
      end
      // ties inside a token go to the smaller reference end
      if (hi_len > token_best_len ||
          (hi_len > 0 && hi_len == token_best_len && hi_end < token_best_end)) begin
         token_best_len = hi_len;
         token_best_end = hi_end;
      end
   endfunction

   function automatic void predict_lcs(logic [CHAR_W-1:0] code, logic has, logic tend,
                                       logic sete);
      bit             closes;
      bit             active;
      lcs_result_type res;
      closes = tend || sete;
      active = token_no >= 1 && token_no <= token_limit;
      if (token_no == 0) begin
         if (has) begin
            if (ref_count < MAX_LEN) begin
               ref_text[ref_count] = code;
               ref_count++;
            end else begin
               ref_long = 1;
            end
         end
      end else if (active && has) begin
         match_char(code);
      end
      if (closes) begin
         if (active && token_best_len > set_best_len) begin
            set_best_len   = token_best_len;
            set_best_start = token_best_end - token_best_len;
         end
         clear_token_runs();
         if (token_no < 256) token_no++;
      end
      if (sete) begin
         res.len   = LEN_W'(set_best_len);
         res.start = POS_W'(set_best_start);
         res.trunc = ref_long;
         pending_lcs.push_back(res);
         clear_lcs_set();
      end
   endfunction

   // ---------------------------------------------------------------- result side

   // Receiver readiness; a requested hold-off is counted down here
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= out_idle_pct);
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      lcs_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lcs.size() == 0) begin
            $error("result beat with no prediction pending");
            error_count++;
         end else begin
            want = pending_lcs.pop_front();
            if (rsp_lcs_length !== want.len) begin
               $error("lcs_length: expected %0d, got %0d", want.len, rsp_lcs_length);
               error_count++;
            end
            if (rsp_lcs_start !== want.start) begin
               $error("lcs_start: expected %0d, got %0d", want.start, rsp_lcs_start);
               error_count++;
            end
            if (rsp_ref_truncated !== want.trunc) begin
               $error("ref_truncated: expected %0d, got %0d", want.trunc,
                      rsp_ref_truncated);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- input side

   // Offer one beat, with random gaps ahead of it, and predict once accepted
   task automatic send_char_beat(logic [CHAR_W-1:0] code, logic has, logic tend,
                                 logic sete);
      @(negedge clock);
      while ($urandom_range(99) < in_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_char_code = code;
      req_has_char  = has;
      req_token_end = tend;
      req_set_end   = sete;
      do @(posedge clock); while (!req_ready);
      predict_lcs(code, has, tend, sete);
      if (has || tend || sete) beats_sent++;
   endtask

   // Send token_buf as one token, closed as asked
   task automatic send_token(close_style_type style, bit last);
      int n;
      n = token_buf.size();
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < noise_pct)
            send_char_beat(CHAR_W'($urandom), 1'b0, 1'b0, 1'b0);
         if (k == n - 1 && style == CLOSE_ON_CHAR)
            send_char_beat(token_buf[k], 1'b1, 1'b1, last);
         else if (k == n - 1 && style == CLOSE_SET_ONLY && last)
            send_char_beat(token_buf[k], 1'b1, 1'b0, 1'b1);
         else
            send_char_beat(token_buf[k], 1'b1, 1'b0, 1'b0);
      end
      // empty token or separate end marker
      if (n == 0 || style == CLOSE_MARKER || (style == CLOSE_SET_ONLY && !last))
         send_char_beat(CHAR_W'($urandom), 1'b0,
                        last ? 1'($urandom_range(1)) : 1'b1, last);
   endtask

   // Let every predicted result drain, then give the unit time to settle
   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_lcs.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_token_limit(int unsigned value);
      wait_quiet();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = CFG_W'(value);
      token_limit = value & 8'hFF;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] draw_char();
      return ($urandom_range(9) == 0) ? CHAR_W'($urandom) : alphabet[$urandom_range(3)];
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      // extreme codes; marker close; ignored charless beat; set end alone
      token_buf = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = '{16'hFFFF, 16'h8000};
      send_token(CLOSE_MARKER, 0);
      send_char_beat(16'h0000, 1'b1, 1'b0, 1'b0);
      send_char_beat(16'hFFFF, 1'b0, 1'b0, 1'b0);
      send_char_beat(16'hFFFF, 1'b1, 1'b0, 1'b0);
      send_char_beat(16'h8000, 1'b1, 1'b1, 1'b0);
      token_buf = '{16'h0001};
      send_token(CLOSE_SET_ONLY, 1);
      // equal runs inside one token: smaller reference end wins
      token_buf = '{16'h0061, 16'h0062, 16'h0078, 16'h0061, 16'h0062};
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = '{16'h0061, 16'h0062};
      send_token(CLOSE_ON_CHAR, 1);
      // reference alone, then a wholly empty set
      token_buf = '{16'h7FFF};
      send_token(CLOSE_ON_CHAR, 1);
      send_char_beat(16'h5555, 1'b0, 1'b1, 1'b1);
   endtask

   task automatic test_long_reference();
      logic [CHAR_W-1:0] full [$];
      // exactly MAX_LEN characters, matched whole
      for (int k = 0; k < MAX_LEN; k++)
         full.push_back({10'($urandom), 6'(k)});
      token_buf = full;
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = full;
      send_token(CLOSE_ON_CHAR, 1);
      // last position alone gives the highest start offset
      token_buf = full;
      send_token(CLOSE_MARKER, 0);
      token_buf = '{full[MAX_LEN-1]};
      send_token(CLOSE_ON_CHAR, 1);
      // overlong reference: tail dropped and flagged
      for (int k = MAX_LEN; k < MAX_LEN + 6; k++)
         full.push_back({10'($urandom), 6'(k)});
      token_buf = full;
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = full[50:MAX_LEN+5];
      send_token(CLOSE_ON_CHAR, 1);
   endtask

   task automatic test_token_limit();
      // one compared token; the longer match after it is ignored
      set_token_limit(1);
      token_buf = '{16'h0068, 16'h0065, 16'h006C, 16'h006C, 16'h006F};
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = '{16'h0065, 16'h006C};
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = '{16'h0068, 16'h0065, 16'h006C, 16'h006C};
      send_token(CLOSE_ON_CHAR, 1);
      // zero compares nothing
      set_token_limit(0);
      token_buf = '{16'h0041, 16'h0042};
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = '{16'h0041, 16'h0042};
      send_token(CLOSE_ON_CHAR, 1);
      // full count: token counter must saturate, not wrap
      set_token_limit(255);
      token_buf = '{16'h0050, 16'h0051, 16'h0052, 16'h0053};
      send_token(CLOSE_ON_CHAR, 0);
      for (int t = 1; t < 255; t++)
         send_char_beat(16'h0000, 1'b0, 1'b1, 1'b0);
      token_buf = '{16'h0050, 16'h0051};
      send_token(CLOSE_ON_CHAR, 0);
      for (int t = 256; t <= 258; t++) begin
         token_buf = '{16'h0050, 16'h0051, 16'h0052, 16'h0053};
         send_token(CLOSE_ON_CHAR, t == 258);
      end
      set_token_limit(2);
      token_buf = '{16'h1234, 16'h4321};
      send_token(CLOSE_ON_CHAR, 0);
      token_buf = '{16'h4321};
      send_token(CLOSE_MARKER, 0);
      token_buf = '{16'h1234, 16'h4321};
      send_token(CLOSE_ON_CHAR, 1);
   endtask

   task automatic test_result_backpressure();
      set_token_limit(CFG_RESET);
      hold_request = 1;
      // short sets keep coming while results back up
      for (int s = 0; s < 8; s++) begin
         token_buf = '{16'(s), 16'hA5A5, 16'h5A5A};
         send_token(CLOSE_ON_CHAR, 0);
         token_buf = '{16'hA5A5, 16'h5A5A};
         send_token(CLOSE_ON_CHAR, 1);
      end
   endtask

   task automatic random_set();
      logic [CHAR_W-1:0] ref_chars [$];
      int                ref_n;
      int                others;
      int                s;
      int                n;
      for (int k = 0; k < 4; k++) alphabet[k] = CHAR_W'($urandom);
      ref_n  = ($urandom_range(19) == 0) ? $urandom_range(72, 58) : $urandom_range(12);
      others = $urandom_range(5);
      for (int k = 0; k < ref_n; k++) ref_chars.push_back(draw_char());
      token_buf = ref_chars;
      send_token(close_style_type'($urandom_range(2)), others == 0);
      for (int t = 1; t <= others; t++) begin
         token_buf.delete();
         if (ref_n > 0 && $urandom_range(99) < 60) begin
            // slice of the reference, lightly mutated
            s = $urandom_range(ref_n - 1);
            n = $urandom_range(1, (ref_n - s < 10) ? ref_n - s : 10);
            if ($urandom_range(3) == 0) token_buf.push_back(draw_char());
            for (int k = 0; k < n; k++)
               token_buf.push_back(($urandom_range(9) == 0) ? draw_char() : ref_chars[s+k]);
            if ($urandom_range(3) == 0) token_buf.push_back(draw_char());
         end else begin
            n = $urandom_range(8);
            for (int k = 0; k < n; k++) token_buf.push_back(draw_char());
         end
         send_token(close_style_type'($urandom_range(2)), t == others);
      end
   endtask

   task automatic test_random_sets();
      int sets;
      sets      = 0;
      noise_pct = 5;
      while (beats_sent < ITEM_TARGET) begin
         if (sets % 8 == 0) begin
            case ((sets / 8) % 7)
               0: set_token_limit(3);
               1: set_token_limit(1);
               2: set_token_limit(255);
               3: set_token_limit(0);
               4: set_token_limit(2);
               5: set_token_limit($urandom_range(1, 255));
               default: set_token_limit(CFG_RESET);
            endcase
         end
         // a stretch with neither side idling
         if (sets >= 16 && sets < 28) begin
            in_idle_pct  = 0;
            out_idle_pct = 0;
         end else begin
            in_idle_pct  = IDLE_PCT;
            out_idle_pct = IDLE_PCT;
         end
         random_set();
         sets++;
      end
      noise_pct = 0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_has_char  = 1'b0;
      req_token_end = 1'b0;
      req_set_end   = 1'b0;
      rsp_ready     = 1'b0;
      token_limit   = CFG_RESET;
      clear_lcs_set();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_long_reference();
      test_token_limit();
      test_result_backpressure();
      test_random_sets();

      wait_quiet();
      if (error_count == 0)
         $display("longest_common_substring_unit_tb: done, clean");
      else
         $display("longest_common_substring_unit_tb: done, errors");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("longest_common_substring_unit_tb: done, errors");
      $finish;
   end

endmodule
